// File: rtl/core/htb_pkg.sv
// Shared types, codes and defaults for the Huffman tree builder.
package htb_pkg;

  localparam int unsigned SymbolsDefault    = 256;
  localparam int unsigned CountWidthDefault = 32;

  localparam logic [8:0] NoNode     = 9'd511;
  localparam logic [8:0] MergedBase = 9'd256;

  typedef enum logic [1:0] {
    FUNC_COUNT = 2'd0,
    FUNC_BUILD = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_NO_TREE  = 2'd2,
    STATUS_RESERVED = 2'd3
  } status_e;

  // One result transaction as it waits for the output register.
  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  left_child;
    logic [8:0]  right_child;
    logic [31:0] node_frequency;
    logic [8:0]  root_node;
    logic [8:0]  symbols_present;
  } htb_res_t;

endpackage

// File: rtl/core/huffman_tree_builder_unit.sv
// Huffman tree builder: byte histogram plus tree construction over RAM-held state.
//
// A count or a read transaction presents its result after a registered RAM read,
// then an update, and a clear or an empty-histogram build needs no RAM access.
// The next transaction is accepted once the result has gone to the output register.
// A build scans the histogram RAM at one entry per cycle. Each of the n - 1 merges
// over a live set of m nodes then makes two linear scans of the node-set RAM plus
// two removal steps and one merge step. The single read port of the node-set RAM
// sets the build time. One transaction is in work at a time; a finished result
// waits in the output register while the next transaction is accepted. Clear
// takes effect at once, with no sweep.
module huffman_tree_builder_unit
  import htb_pkg::*;
#(
  parameter int unsigned SYMBOLS     = SymbolsDefault,
  parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  data_byte_i,
  input  logic [8:0]  node_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [8:0]  left_child_o,
  output logic [8:0]  right_child_o,
  output logic [31:0] node_frequency_o,
  output logic [8:0]  root_node_o,
  output logic [8:0]  symbols_present_o
);

  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned LW = $clog2(SYMBOLS);
  localparam int unsigned HW = $clog2(SYMBOLS + 1);
  localparam int unsigned MD = SYMBOLS - 1;
  localparam int unsigned MA = (MD > 1) ? $clog2(MD) : 1;
  localparam int unsigned EW = 9 + CW;
  localparam logic [CW-1:0] CountMax = {CW{1'b1}};

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_COUNT = 8'b0000_0010,
    ST_READ  = 8'b0000_0100,
    ST_LOAD  = 8'b0000_1000,
    ST_SCAN  = 8'b0001_0000,
    ST_TAKE  = 8'b0010_0000,
    ST_MERGE = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_e;

  // Clip a count to the 32-bit result field.
  function automatic logic [31:0] sat32(input logic [CW-1:0] f);
    logic [63:0] fx;
    fx = 64'(f);
    return (|fx[63:32]) ? 32'hFFFF_FFFF : fx[31:0];
  endfunction

  state_e          state_q, state_d;
  logic [SYMBOLS-1:0] lv_q, lv_d;
  logic [HW-1:0]   size_q, size_d;
  logic [LW-1:0]   merges_q, merges_d;
  logic [8:0]      distinct_q, distinct_d;
  logic [8:0]      root_q, root_d;
  logic            built_q, built_d;
  logic [HW-1:0]   ptr_q, ptr_d;
  logic            pv_q, pv_d;
  logic [HW-1:0]   pp_q, pp_d;
  logic [LW-1:0]   byte_q, byte_d;
  logic            rd_leaf_q, rd_leaf_d;
  logic            rd_mrg_q, rd_mrg_d;
  logic            take_q, take_d;
  logic [EW-1:0]   best_q, best_d;
  logic [LW-1:0]   bpos_q, bpos_d;
  logic [EW-1:0]   last_q, last_d;
  logic [EW-1:0]   a_q, a_d;
  logic [EW-1:0]   first_q, first_d;
  htb_res_t        res_q, res_d, out_q;
  logic            out_valid_q;

  // RAM ports.
  logic          leaf_we;
  logic [LW-1:0] leaf_waddr, leaf_raddr;
  logic [CW-1:0] leaf_wdata, leaf_rdata;
  logic          heap_we;
  logic [LW-1:0] heap_waddr, heap_raddr;
  logic [EW-1:0] heap_wdata, heap_rdata;
  logic          mrg_we;
  logic [MA-1:0] mrg_waddr, mrg_raddr;
  logic [17:0]   kids_wdata, kids_rdata;
  logic [CW-1:0] mf_wdata, mf_rdata;

  htb_ram #(.Width(CW), .Depth(SYMBOLS)) u_leaf_ram (
    .clk_i, .we_i(leaf_we), .waddr_i(leaf_waddr), .wdata_i(leaf_wdata),
    .raddr_i(leaf_raddr), .rdata_o(leaf_rdata)
  );

  htb_ram #(.Width(EW), .Depth(SYMBOLS)) u_heap_ram (
    .clk_i, .we_i(heap_we), .waddr_i(heap_waddr), .wdata_i(heap_wdata),
    .raddr_i(heap_raddr), .rdata_o(heap_rdata)
  );

  htb_ram #(.Width(18), .Depth(MD)) u_kids_ram (
    .clk_i, .we_i(mrg_we), .waddr_i(mrg_waddr), .wdata_i(kids_wdata),
    .raddr_i(mrg_raddr), .rdata_o(kids_rdata)
  );

  htb_ram #(.Width(CW), .Depth(MD)) u_mfreq_ram (
    .clk_i, .we_i(mrg_we), .waddr_i(mrg_waddr), .wdata_i(mf_wdata),
    .raddr_i(mrg_raddr), .rdata_o(mf_rdata)
  );

  logic          in_acc;
  logic          out_free;
  logic          idx_leaf, idx_mrg;
  logic [CW-1:0] old_cnt, new_cnt;
  logic [CW-1:0] e_f, b_f;
  logic [8:0]    e_n, b_n;
  logic [CW:0]   sum_w;
  logic [CW-1:0] sum_s;
  logic [8:0]    new_node;
  logic [EW-1:0] ld_entry;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign idx_leaf = (10'(node_index_i) < 10'(SYMBOLS));
  assign idx_mrg  = node_index_i[8] && (9'(node_index_i[7:0]) < 9'(merges_q));

  assign old_cnt  = lv_q[byte_q] ? leaf_rdata : '0;
  assign new_cnt  = (old_cnt == CountMax) ? old_cnt : old_cnt + 1'b1;

  assign e_n = heap_rdata[EW-1:CW];
  assign e_f = heap_rdata[CW-1:0];
  assign b_n = best_q[EW-1:CW];
  assign b_f = best_q[CW-1:0];

  assign sum_w    = {1'b0, a_q[CW-1:0]} + {1'b0, best_q[CW-1:0]};
  assign sum_s    = sum_w[CW] ? CountMax : sum_w[CW-1:0];
  assign new_node = MergedBase + 9'(merges_q);
  assign ld_entry = {9'(pp_q), leaf_rdata};

  // Control sequencer.
  always_comb begin
    state_d    = state_q;
    lv_d       = lv_q;
    size_d     = size_q;
    merges_d   = merges_q;
    distinct_d = distinct_q;
    root_d     = root_q;
    built_d    = built_q;
    ptr_d      = ptr_q;
    pv_d       = 1'b0;
    pp_d       = pp_q;
    byte_d     = byte_q;
    rd_leaf_d  = rd_leaf_q;
    rd_mrg_d   = rd_mrg_q;
    take_d     = take_q;
    best_d     = best_q;
    bpos_d     = bpos_q;
    last_d     = last_q;
    a_d        = a_q;
    first_d    = first_q;
    res_d      = res_q;
    leaf_we    = 1'b0;
    leaf_waddr = byte_q;
    leaf_wdata = new_cnt;
    leaf_raddr = LW'(data_byte_i);
    heap_we    = 1'b0;
    heap_waddr = LW'(size_q);
    heap_wdata = ld_entry;
    heap_raddr = LW'(ptr_q);
    mrg_we     = 1'b0;
    mrg_waddr  = MA'(merges_q);
    kids_wdata = {a_q[EW-1:CW], b_n};
    mf_wdata   = sum_s;
    mrg_raddr  = MA'(node_index_i[7:0]);

    case (state_q)
      ST_IDLE: begin
        if (func_i == FUNC_READ) begin
          leaf_raddr = LW'(node_index_i);
        end
        if (in_acc) begin
          res_d = '{status: STATUS_OK, left_child: NoNode, right_child: NoNode,
                    node_frequency: 32'd0, root_node: NoNode,
                    symbols_present: distinct_q};
          case (func_i)
            FUNC_COUNT: begin
              built_d  = 1'b0;
              root_d   = NoNode;
              merges_d = '0;
              size_d   = '0;
              byte_d   = LW'(data_byte_i);
              if (9'(data_byte_i) < 9'(SYMBOLS)) begin
                state_d = ST_COUNT;
              end else begin
                state_d = ST_DONE;
              end
            end
            FUNC_BUILD: begin
              merges_d = '0;
              size_d   = '0;
              if (distinct_q == 9'd0) begin
                built_d      = 1'b0;
                root_d       = NoNode;
                res_d.status = STATUS_EMPTY;
                state_d      = ST_DONE;
              end else begin
                ptr_d   = '0;
                state_d = ST_LOAD;
              end
            end
            FUNC_READ: begin
              if (!built_q) begin
                res_d.status = STATUS_NO_TREE;
                state_d      = ST_DONE;
              end else begin
                rd_leaf_d = idx_leaf;
                rd_mrg_d  = idx_mrg;
                byte_d    = LW'(node_index_i);
                state_d   = ST_READ;
              end
            end
            default: begin
              lv_d                  = '0;
              distinct_d            = '0;
              built_d               = 1'b0;
              root_d                = NoNode;
              merges_d              = '0;
              size_d                = '0;
              res_d.symbols_present = 9'd0;
              state_d               = ST_DONE;
            end
          endcase
        end
      end

      // Histogram update with the count just read.
      ST_COUNT: begin
        leaf_we      = 1'b1;
        lv_d[byte_q] = 1'b1;
        if (old_cnt == '0) begin
          distinct_d = distinct_q + 9'd1;
        end
        res_d.node_frequency  = sat32(new_cnt);
        res_d.symbols_present = (old_cnt == '0) ? distinct_q + 9'd1 : distinct_q;
        state_d = ST_DONE;
      end

      ST_READ: begin
        res_d.root_node = root_q;
        if (rd_leaf_q) begin
          res_d.node_frequency = lv_q[byte_q] ? sat32(leaf_rdata) : 32'd0;
        end else if (rd_mrg_q) begin
          res_d.left_child     = kids_rdata[17:9];
          res_d.right_child    = kids_rdata[8:0];
          res_d.node_frequency = sat32(mf_rdata);
        end
        state_d = ST_DONE;
      end

      // Stream the histogram into the node set, skipping empty bins.
      ST_LOAD: begin
        leaf_raddr = LW'(ptr_q);
        if (ptr_q < HW'(SYMBOLS)) begin
          ptr_d = ptr_q + 1'b1;
          pv_d  = 1'b1;
          pp_d  = ptr_q;
        end
        if (pv_q && lv_q[LW'(pp_q)] && (leaf_rdata != '0)) begin
          heap_we = 1'b1;
          size_d  = size_q + 1'b1;
          if (size_q == '0) begin
            first_d = ld_entry;
          end
        end
        if ((ptr_q == HW'(SYMBOLS)) && !pv_q) begin
          if (size_q == HW'(1)) begin
            built_d = 1'b1;
            root_d  = first_q[EW-1:CW];
            res_d.node_frequency = sat32(first_q[CW-1:0]);
            res_d.root_node      = first_q[EW-1:CW];
            state_d = ST_DONE;
          end else begin
            take_d  = 1'b0;
            ptr_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end

      // Linear search for the lowest (frequency, index) node.
      ST_SCAN: begin
        if (ptr_q < size_q) begin
          ptr_d = ptr_q + 1'b1;
          pv_d  = 1'b1;
          pp_d  = ptr_q;
        end
        if (pv_q) begin
          if ((pp_q == '0) || (e_f < b_f) || ((e_f == b_f) && (e_n < b_n))) begin
            best_d = heap_rdata;
            bpos_d = LW'(pp_q);
          end
          if (pp_q == size_q - 1'b1) begin
            last_d = heap_rdata;
          end
        end
        if ((ptr_q == size_q) && !pv_q) begin
          state_d = ST_TAKE;
        end
      end

      // Remove the minimum by moving the last node into its slot.
      ST_TAKE: begin
        heap_waddr = bpos_q;
        heap_wdata = last_q;
        heap_we    = (HW'(bpos_q) != size_q - 1'b1);
        size_d     = size_q - 1'b1;
        if (!take_q) begin
          a_d     = best_q;
          take_d  = 1'b1;
          ptr_d   = '0;
          state_d = ST_SCAN;
        end else begin
          state_d = ST_MERGE;
        end
      end

      // Record the merged node and put it back into the set.
      ST_MERGE: begin
        mrg_we     = 1'b1;
        heap_we    = 1'b1;
        heap_wdata = {new_node, sum_s};
        size_d     = size_q + 1'b1;
        merges_d   = merges_q + 1'b1;
        if (size_q != '0) begin
          take_d  = 1'b0;
          ptr_d   = '0;
          state_d = ST_SCAN;
        end else begin
          built_d = 1'b1;
          root_d  = new_node;
          res_d.left_child     = a_q[EW-1:CW];
          res_d.right_child    = b_n;
          res_d.node_frequency = sat32(sum_s);
          res_d.root_node      = new_node;
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lv_q        <= '0;
      size_q      <= '0;
      merges_q    <= '0;
      distinct_q  <= '0;
      root_q      <= NoNode;
      built_q     <= 1'b0;
      ptr_q       <= '0;
      pv_q        <= 1'b0;
      take_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      lv_q       <= lv_d;
      size_q     <= size_d;
      merges_q   <= merges_d;
      distinct_q <= distinct_d;
      root_q     <= root_d;
      built_q    <= built_d;
      ptr_q      <= ptr_d;
      pv_q       <= pv_d;
      take_q     <= take_d;
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    pp_q      <= pp_d;
    byte_q    <= byte_d;
    rd_leaf_q <= rd_leaf_d;
    rd_mrg_q  <= rd_mrg_d;
    best_q    <= best_d;
    bpos_q    <= bpos_d;
    last_q    <= last_d;
    a_q       <= a_d;
    first_q   <= first_d;
    res_q     <= res_d;
    if ((state_q == ST_DONE) && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign left_child_o      = out_q.left_child;
  assign right_child_o     = out_q.right_child;
  assign node_frequency_o  = out_q.node_frequency;
  assign root_node_o       = out_q.root_node;
  assign symbols_present_o = out_q.symbols_present;

endmodule

// File: rtl/core/htb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module htb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/htb_checker.sv
// Port-level checks for the Huffman tree builder, bound to its top level.
module htb_checker
  import htb_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [8:0]  left_child_o,
  input logic [8:0]  root_node_o,
  input logic [31:0] node_frequency_o
);

  // A stalled result transaction holds its status and root node.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(root_node_o))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != STATUS_RESERVED)
    else $error("reserved status code");

  // Without a tree there is no root and no frequency.
  a_no_tree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_NO_TREE) |->
      (root_node_o == NoNode) && (node_frequency_o == 32'd0))
    else $error("read before build reported data");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_EMPTY) |->
      (root_node_o == NoNode) && (left_child_o == NoNode))
    else $error("empty build reported a tree");

endmodule

bind huffman_tree_builder_unit htb_checker u_htb_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .status_o         (status_o),
  .left_child_o     (left_child_o),
  .root_node_o      (root_node_o),
  .node_frequency_o (node_frequency_o)
);
